FILE: rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, idle during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, idle during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/pfa_pkg.sv
// Package for the partition fit allocator: field widths, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

    // Parameter defaults
    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    // Fixed port field widths
    localparam int IN_INDEX_W = 4;
    localparam int IN_SIZE_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'b1;

    // Register reset values
    localparam logic [MODE_W-1:0]  FIT_MODE_RESET   = 2'd0;
    localparam logic [COUNT_W-1:0] PART_COUNT_RESET = 5'd16;

    // Placement rules; the unused code behaves as first fit
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // Operations
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Control from the sequencer to the fit unit
    typedef struct packed {
        logic              clear;   // start of a new item: drop the pick
        logic              eval_v;  // an entry is presented this cycle
        logic              used;    // that entry is already taken
        logic [MODE_W-1:0] mode;    // placement rule
    } fit_ctrl_t;

endpackage

FILE: rtl/pfa_in_if.sv
// Input channel of the allocator: valid/ready plus one item.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

interface pfa_in_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [pfa_pkg::IN_INDEX_W-1:0]  partition_index;
    logic [pfa_pkg::IN_SIZE_W-1:0]   size_value;
    logic                            last_request;

    modport source (output valid, operation, partition_index, size_value, last_request,
                    input ready);
    modport sink   (input valid, operation, partition_index, size_value, last_request,
                    output ready);
endinterface

FILE: rtl/pfa_out_if.sv
// Result channel of the allocator: valid/ready plus one result.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

interface pfa_out_if;
    logic                            valid;
    logic                            ready;
    logic                            granted;
    logic [pfa_pkg::IN_INDEX_W-1:0]  block_index;
    logic [pfa_pkg::IN_SIZE_W-1:0]   block_size_before;
    logic [pfa_pkg::IN_SIZE_W-1:0]   block_remaining;

    modport source (output valid, granted, block_index, block_size_before, block_remaining,
                    input ready);
    modport sink   (input valid, granted, block_index, block_size_before, block_remaining,
                    output ready);
endinterface

FILE: rtl/pfa_ram.sv
// Single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/pfa_fit_unit.sv
// Shared fit unit: one subtract and one compare per beat, holds the running pick.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_fit_unit #(
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfa_pkg::fit_ctrl_t    ctrl,
    input  logic [IDX_W-1:0]      eval_idx,
    input  logic [SIZE_BITS-1:0]  cur_size,
    input  logic [SIZE_BITS-1:0]  req_size,
    output logic                  found,
    output logic [IDX_W-1:0]      pick_idx,
    output logic [SIZE_BITS-1:0]  pick_before,
    output logic [SIZE_BITS-1:0]  pick_diff
);

    logic                 found_reg;
    logic [IDX_W-1:0]     pick_idx_reg;
    logic [SIZE_BITS-1:0] pick_before_reg;
    logic [SIZE_BITS-1:0] pick_diff_reg;
    logic [SIZE_BITS:0]   sub;
    logic [SIZE_BITS-1:0] diff;
    logic                 fits;
    logic                 better;
    logic                 take;

    // Leftover and fit test from one subtractor: borrow means too small
    assign sub  = {1'b0, cur_size} - {1'b0, req_size};
    assign diff = sub[SIZE_BITS-1:0];
    assign fits = !ctrl.used && !sub[SIZE_BITS];

    // Strict compare keeps ties on the lower index
    always_comb
    begin
        unique case (ctrl.mode)
            pfa_pkg::MODE_BEST:  better = diff < pick_diff_reg;
            pfa_pkg::MODE_WORST: better = diff > pick_diff_reg;
            default:             better = 1'b0;
        endcase
    end

    assign take = ctrl.eval_v && fits && (!found_reg || better);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    // Pick payload
    always_ff @(posedge clk)
    begin
        if (take && !ctrl.clear)
        begin
            pick_idx_reg    <= eval_idx;
            pick_before_reg <= cur_size;
            pick_diff_reg   <= diff;
        end
    end

    assign found       = found_reg;
    assign pick_idx    = pick_idx_reg;
    assign pick_before = pick_before_reg;
    assign pick_diff   = pick_diff_reg;

endmodule

FILE: rtl/partition_fit_allocator_core.sv
// Top level of the partition fit allocator: sequencer, size RAMs, mark flags.
// Depends on pfa_pkg, pfa_in_if, pfa_out_if, pfa_ram, pfa_fit_unit, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Fixed-partition allocator (first, best or worst fit). A load beat writes the size
// RAMs when accepted and then passes through the update step. A request beat passes
// through an accept step, a scan that issues one size RAM read per partition for
// n = min(partition_count, MAX_PARTITIONS) partitions, the registered RAM read into
// the single subtract/compare fit unit, the fit unit's pick register and an update
// step. First fit stops issuing reads once a hit is recorded. The block takes one
// item at a time, but a finished result may wait in the output register while the
// next item is accepted; the update cycle of that next item waits until the register
// is free. End of run clears the per-partition modified flags, so current sizes fall
// back to the originals; there is no restore sweep and no clearing pass after reset.
module partition_fit_allocator_core #(
    parameter int MAX_PARTITIONS = pfa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pfa_in_if.sink                           in_ch,
    pfa_out_if.source                        out_ch,
    input  logic                             cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(MAX_PARTITIONS);
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    // Configuration
    logic [pfa_pkg::MODE_W-1:0]  fit_mode_reg;
    logic [pfa_pkg::COUNT_W-1:0] part_count_reg;

    // Sequencer and item registers
    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     addr_reg, addr_next;
    logic [CNT_W-1:0]     scan_cnt_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic                 last_reg;
    logic                 is_req_reg;
    logic                 eval_v_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic                 used_q_reg;
    logic                 dirty_q_reg;
    logic                 loaded_q_reg;

    // Per-partition flags
    logic [MAX_PARTITIONS-1:0] used_reg, used_next;
    logic [MAX_PARTITIONS-1:0] dirty_reg, dirty_next;
    logic [MAX_PARTITIONS-1:0] loaded_reg, loaded_next;

    // Output register
    logic                          out_valid_reg;
    logic                          out_granted_reg;
    logic [pfa_pkg::IN_INDEX_W-1:0] out_index_reg;
    logic [pfa_pkg::IN_SIZE_W-1:0]  out_before_reg;
    logic [pfa_pkg::IN_SIZE_W-1:0]  out_remain_reg;

    logic                 accept;
    logic                 load_wr;
    logic [IDX_W-1:0]     load_addr;
    logic [SIZE_BITS-1:0] in_size;
    logic [CNT_W-1:0]     count_clamped;
    logic                 issue;
    logic                 scan_done;
    logic                 out_free;
    logic                 upd_go;
    logic                 upd_wr;
    logic                 run_end;
    logic [IDX_W-1:0]     addr_idx;
    logic                 cur_we;
    logic [IDX_W-1:0]     cur_waddr;
    logic [SIZE_BITS-1:0] cur_wdata;
    logic [SIZE_BITS-1:0] cur_rd;
    logic [SIZE_BITS-1:0] orig_rd;
    logic [SIZE_BITS-1:0] eval_size;
    logic                 first_only;

    pfa_pkg::fit_ctrl_t   fit_ctrl;
    logic                 found;
    logic [IDX_W-1:0]     pick_idx;
    logic [SIZE_BITS-1:0] pick_before;
    logic [SIZE_BITS-1:0] pick_diff;

    // Handshake and input decode
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_size     = SIZE_BITS'(in_ch.size_value);
    assign load_addr   = IDX_W'(in_ch.partition_index);
    assign load_wr     = accept && (in_ch.operation == pfa_pkg::OP_LOAD)
                         && (32'(in_ch.partition_index) < 32'(MAX_PARTITIONS));
    assign count_clamped = (32'(part_count_reg) > 32'(MAX_PARTITIONS))
                           ? CNT_W'(MAX_PARTITIONS) : CNT_W'(part_count_reg);

    // Scan control: first fit stops once a hit is recorded
    assign first_only = (fit_mode_reg != pfa_pkg::MODE_BEST)
                        && (fit_mode_reg != pfa_pkg::MODE_WORST);
    assign addr_idx   = addr_reg[IDX_W-1:0];
    assign issue      = (state_reg == ST_SCAN) && (addr_reg < scan_cnt_reg)
                        && !(found && first_only);
    assign scan_done  = (state_reg == ST_SCAN) && !issue && !eval_v_reg;

    // Update step
    assign out_free = !out_valid_reg || out_ch.ready;
    assign upd_go   = (state_reg == ST_UPDATE) && out_free;
    assign upd_wr   = upd_go && is_req_reg && found;
    assign run_end  = upd_go && is_req_reg && last_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg   <= pfa_pkg::FIT_MODE_RESET;
            part_count_reg <= pfa_pkg::PART_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfa_pkg::REG_FIT_MODE:   fit_mode_reg   <= cfg_data[pfa_pkg::MODE_W-1:0];
                pfa_pkg::REG_PART_COUNT: part_count_reg <= cfg_data[pfa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = '0;
                    state_next = (in_ch.operation == pfa_pkg::OP_REQUEST) ? ST_SCAN
                                                                          : ST_UPDATE;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + CNT_W'(1);
                end
                if (scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            addr_reg   <= '0;
            eval_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            eval_v_reg <= issue;
        end
    end

    // Item and read-stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            size_reg     <= in_size;
            last_reg     <= in_ch.last_request;
            is_req_reg   <= (in_ch.operation == pfa_pkg::OP_REQUEST);
            scan_cnt_reg <= count_clamped;
        end
        if (issue)
        begin
            eval_idx_reg <= addr_idx;
            used_q_reg   <= used_reg[addr_idx];
            dirty_q_reg  <= dirty_reg[addr_idx];
            loaded_q_reg <= loaded_reg[addr_idx];
        end
    end

    // Partition flags: modified entries read the current RAM, others the original
    always_comb
    begin
        used_next   = used_reg;
        dirty_next  = dirty_reg;
        loaded_next = loaded_reg;
        if (load_wr)
        begin
            loaded_next[load_addr] = 1'b1;
            dirty_next[load_addr]  = 1'b0;
        end
        if (upd_wr)
        begin
            used_next[pick_idx]  = 1'b1;
            dirty_next[pick_idx] = 1'b1;
        end
        if (run_end)
        begin
            used_next  = '0;
            dirty_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            dirty_reg  <= '0;
            loaded_reg <= '0;
        end
        else
        begin
            used_reg   <= used_next;
            dirty_reg  <= dirty_next;
            loaded_reg <= loaded_next;
        end
    end

    // Size RAMs
    assign cur_we    = load_wr || upd_wr;
    assign cur_waddr = upd_wr ? pick_idx : load_addr;
    assign cur_wdata = upd_wr ? pick_diff : in_size;

    pfa_ram #(
        .DEPTH (MAX_PARTITIONS),
        .WIDTH (SIZE_BITS)
    ) u_orig_ram (
        .clk   (clk),
        .we    (load_wr),
        .waddr (load_addr),
        .wdata (in_size),
        .raddr (addr_idx),
        .rdata (orig_rd)
    );

    pfa_ram #(
        .DEPTH (MAX_PARTITIONS),
        .WIDTH (SIZE_BITS)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .raddr (addr_idx),
        .rdata (cur_rd)
    );

    // Effective current size; an entry never loaded reads as zero
    assign eval_size = dirty_q_reg ? cur_rd : (loaded_q_reg ? orig_rd : '0);

    assign fit_ctrl.clear  = accept;
    assign fit_ctrl.eval_v = eval_v_reg;
    assign fit_ctrl.used   = used_q_reg;
    assign fit_ctrl.mode   = fit_mode_reg;

    pfa_fit_unit #(
        .IDX_W     (IDX_W),
        .SIZE_BITS (SIZE_BITS)
    ) u_fit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (fit_ctrl),
        .eval_idx    (eval_idx_reg),
        .cur_size    (eval_size),
        .req_size    (size_reg),
        .found       (found),
        .pick_idx    (pick_idx),
        .pick_before (pick_before),
        .pick_diff   (pick_diff)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (upd_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            out_granted_reg <= is_req_reg && found;
            out_index_reg   <= (is_req_reg && found) ? pfa_pkg::IN_INDEX_W'(pick_idx) : '0;
            out_before_reg  <= (is_req_reg && found) ? pfa_pkg::IN_SIZE_W'(pick_before)
                                                     : '0;
            out_remain_reg  <= (is_req_reg && found) ? pfa_pkg::IN_SIZE_W'(pick_diff) : '0;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.granted           = out_granted_reg;
    assign out_ch.block_index       = out_index_reg;
    assign out_ch.block_size_before = out_before_reg;
    assign out_ch.block_remaining   = out_remain_reg;

    // Checks
    `ASSERT_IMPLIES(a_remain_le_before, clk, rst_n, out_ch.valid && out_ch.granted,
                    out_ch.block_remaining <= out_ch.block_size_before)
    `ASSERT_IMPLIES(a_no_grant_zero, clk, rst_n, out_ch.valid && !out_ch.granted,
                    out_ch.block_index == '0 && out_ch.block_remaining == '0)
    `ASSERT_IMPLIES(a_scan_bound, clk, rst_n, state_reg == ST_SCAN, addr_reg <= scan_cnt_reg)
    `ASSERT_NEXT(a_pick_marked, clk, rst_n, upd_wr && !run_end,
                 used_reg[$past(pick_idx)] && dirty_reg[$past(pick_idx)])

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for partition_fit_allocator_core: load and request beats with random gaps and
// result stalls; a local placement model predicts every result beat, which is then checked.
// Depends on pfa_pkg, pfa_in_if, pfa_out_if and the allocator RTL.

module tb;

    localparam int NPART        = pfa_pkg::MAX_PARTITIONS_DEF;
    localparam int HOLD_LEN     = 400;
    localparam int WDOG_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic                           op;
        logic [pfa_pkg::IN_INDEX_W-1:0] idx;
        logic [pfa_pkg::IN_SIZE_W-1:0]  size;
        logic                           last;
    } alloc_req_t;

    typedef struct packed {
        logic                           granted;
        logic [pfa_pkg::IN_INDEX_W-1:0] index;
        logic [pfa_pkg::IN_SIZE_W-1:0]  size_before;
        logic [pfa_pkg::IN_SIZE_W-1:0]  remaining;
    } grant_t;

    localparam int REQ_W = $bits(alloc_req_t);

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data;

    pfa_in_if  in_ch ();
    pfa_out_if out_ch ();

    partition_fit_allocator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Allocator model state and registers
    logic [pfa_pkg::IN_SIZE_W-1:0] orig_size [NPART];
    logic [pfa_pkg::IN_SIZE_W-1:0] cur_size  [NPART];
    logic [NPART-1:0]              taken;
    logic [pfa_pkg::MODE_W-1:0]    mode_reg;
    logic [pfa_pkg::COUNT_W-1:0]   count_reg;

    grant_t expected_grants [$];
    int     errors;
    int     prints;
    int     items_sent;
    int     idle_cycles;
    bit     gaps_on;
    bit     stall_on;
    int     hold_seq;
    int     hold_seen;
    int     hold_cnt;

    always #5 clk = ~clk;

    // Placement model: applies one accepted beat and returns its result
    function automatic grant_t predict_grant(alloc_req_t r);
        grant_t                         g;
        int                             lim;
        bit                             found;
        logic [pfa_pkg::IN_INDEX_W-1:0] pick;
        logic [pfa_pkg::IN_SIZE_W-1:0]  pick_left;
        logic [pfa_pkg::IN_SIZE_W-1:0]  left;
        g         = '0;
        found     = 1'b0;
        pick      = '0;
        pick_left = '0;
        if (r.op == pfa_pkg::OP_LOAD)
        begin
            orig_size[r.idx] = r.size;
            cur_size[r.idx]  = r.size;
            return g;
        end
        lim = (count_reg > NPART) ? NPART : int'(count_reg);
        for (int j = 0; j < lim; j++)
        begin
            if (taken[j] || r.size > cur_size[j])
                continue;
            left = cur_size[j] - r.size;
            if (!found)
            begin
                found     = 1'b1;
                pick      = pfa_pkg::IN_INDEX_W'(j);
                pick_left = left;
                if (mode_reg != pfa_pkg::MODE_BEST && mode_reg != pfa_pkg::MODE_WORST)
                    break;
            end
            else if (mode_reg == pfa_pkg::MODE_BEST && left < pick_left)
            begin
                pick      = pfa_pkg::IN_INDEX_W'(j);
                pick_left = left;
            end
            else if (mode_reg == pfa_pkg::MODE_WORST && left > pick_left)
            begin
                pick      = pfa_pkg::IN_INDEX_W'(j);
                pick_left = left;
            end
        end
        if (found)
        begin
            g.granted      = 1'b1;
            g.index        = pick;
            g.size_before  = cur_size[pick];
            g.remaining    = pick_left;
            cur_size[pick] = pick_left;
            taken[pick]    = 1'b1;
        end
        // end of run: sizes back to originals, marks cleared
        if (r.last)
        begin
            for (int j = 0; j < NPART; j++)
                cur_size[j] = orig_size[j];
            taken = '0;
        end
        return g;
    endfunction

    task automatic report_mismatch(string what, logic [pfa_pkg::IN_SIZE_W-1:0] got,
                                   logic [pfa_pkg::IN_SIZE_W-1:0] want);
        errors++;
        if (prints < MAX_PRINTS)
        begin
            $display("tb: mismatch %s got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
            prints++;
        end
    endtask

    // Offer one beat after a random gap; the model runs when it is accepted
    task automatic send_item(alloc_req_t r);
        int gap;
        gap = 0;
        if (gaps_on)
            while ($urandom_range(99) < 25)
                gap++;
        if (gap > 0)
        begin
            in_ch.valid           <= 1'b0;
            in_ch.operation       <= 1'($urandom_range(1));
            in_ch.partition_index <= pfa_pkg::IN_INDEX_W'($urandom);
            in_ch.size_value      <= pfa_pkg::IN_SIZE_W'($urandom);
            in_ch.last_request    <= 1'($urandom_range(1));
            repeat (gap) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.operation       <= r.op;
        in_ch.partition_index <= r.idx;
        in_ch.size_value      <= r.size;
        in_ch.last_request    <= r.last;
        do
            @(negedge clk);
        while (in_ch.ready !== 1'b1);
        @(posedge clk);
        expected_grants.push_back(predict_grant(r));
        items_sent++;
    endtask

    task automatic send_load(logic [pfa_pkg::IN_INDEX_W-1:0] idx,
                             logic [pfa_pkg::IN_SIZE_W-1:0] size, logic last);
        send_item({pfa_pkg::OP_LOAD, idx, size, last});
    endtask

    task automatic send_request(logic [pfa_pkg::IN_SIZE_W-1:0] size, logic last);
        send_item({pfa_pkg::OP_REQUEST, pfa_pkg::IN_INDEX_W'($urandom), size, last});
    endtask

    // Drop valid and wait until every predicted result beat has been taken
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_grants.size() != 0)
            @(posedge clk);
    endtask

    // Register write; only called while the block is idle
    task automatic write_reg(logic [pfa_pkg::CFG_IDX_W-1:0] index,
                             logic [pfa_pkg::CFG_DATA_W-1:0] data);
        if (index == pfa_pkg::REG_FIT_MODE)
            mode_reg = data[pfa_pkg::MODE_W-1:0];
        else if (index == pfa_pkg::REG_PART_COUNT)
            count_reg = data[pfa_pkg::COUNT_W-1:0];
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One run: a few loads, then requests with the last one ending the run unless it is a random beat
    task automatic run_round();
        int                            nload;
        int                            nreq;
        int                            pj;
        logic [pfa_pkg::IN_SIZE_W-1:0] span;
        logic [pfa_pkg::IN_SIZE_W-1:0] sz;
        span  = ($urandom_range(1) == 1) ? 16'hFFFF : 16'd63;
        nload = $urandom_range(1, 8);
        nreq  = $urandom_range(1, 6);
        for (int k = 0; k < nload; k++)
            send_load(pfa_pkg::IN_INDEX_W'($urandom),
                      pfa_pkg::IN_SIZE_W'($urandom_range(0, span)),
                      1'($urandom_range(1)));
        for (int k = 0; k < nreq; k++)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(alloc_req_t'(REQ_W'($urandom)));
            end
            else
            begin
                if ($urandom_range(9) < 3)
                begin
                    pj = $urandom_range(NPART - 1);
                    sz = cur_size[pj];
                end
                else
                begin
                    sz = pfa_pkg::IN_SIZE_W'($urandom_range(0, span));
                end
                send_request(sz, k == nreq - 1);
            end
        end
    endtask

    // Result checker: a beat seen with valid and ready at the falling edge is taken next rise
    always @(negedge clk)
    begin
        grant_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_grants.size() == 0)
            begin
                report_mismatch("unexpected result beat, index",
                                pfa_pkg::IN_SIZE_W'(out_ch.block_index), '0);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (out_ch.granted !== want.granted)
                    report_mismatch("granted", pfa_pkg::IN_SIZE_W'(out_ch.granted),
                                    pfa_pkg::IN_SIZE_W'(want.granted));
                if (out_ch.block_index !== want.index)
                    report_mismatch("block_index", pfa_pkg::IN_SIZE_W'(out_ch.block_index),
                                    pfa_pkg::IN_SIZE_W'(want.index));
                if (out_ch.block_size_before !== want.size_before)
                    report_mismatch("block_size_before", out_ch.block_size_before,
                                    want.size_before);
                if (out_ch.block_remaining !== want.remaining)
                    report_mismatch("block_remaining", out_ch.block_remaining,
                                    want.remaining);
            end
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen    <= hold_seq;
            hold_cnt     <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt     <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!stall_on)
        begin
            out_ch.ready <= 1'b1;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= 25);
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(negedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Empty partitions after reset: only zero-size requests fit
    task automatic test_reset_state();
        send_request(16'd0, 1'b0);
        send_request(16'd1, 1'b0);
        send_request(16'd0, 1'b1);
        settle();
    endtask

    // First, best and worst fit on a fixed layout, ties, exact fit, unused mode code
    task automatic test_fit_modes();
        write_reg(pfa_pkg::REG_FIT_MODE, pfa_pkg::CFG_DATA_W'(pfa_pkg::MODE_FIRST));
        send_load(4'd0, 16'd100, 1'b0);
        send_load(4'd1, 16'd40, 1'b0);
        send_load(4'd2, 16'hFFFF, 1'b0);
        send_load(4'd3, 16'd40, 1'b0);
        send_load(4'd15, 16'd0, 1'b1);
        send_request(16'd40, 1'b0);
        send_request(16'hFFFF, 1'b1);
        settle();
        write_reg(pfa_pkg::REG_FIT_MODE, pfa_pkg::CFG_DATA_W'(pfa_pkg::MODE_BEST));
        send_request(16'd40, 1'b0);
        send_request(16'd40, 1'b0);
        send_request(16'd0, 1'b1);
        settle();
        write_reg(pfa_pkg::REG_FIT_MODE, pfa_pkg::CFG_DATA_W'(pfa_pkg::MODE_WORST));
        send_request(16'd1, 1'b0);
        send_request(16'hFFFF, 1'b1);
        settle();
        // code 3 with the upper data bits set acts as first fit
        write_reg(pfa_pkg::REG_FIT_MODE, 5'b11111);
        send_request(16'd50, 1'b1);
        settle();
    endtask

    // Partition count of zero, above the maximum, and one
    task automatic test_count_limits();
        write_reg(pfa_pkg::REG_PART_COUNT, 5'd0);
        send_request(16'd0, 1'b0);
        settle();
        write_reg(pfa_pkg::REG_PART_COUNT, 5'd31);
        send_request(16'd0, 1'b1);
        settle();
        write_reg(pfa_pkg::REG_PART_COUNT, 5'd1);
        send_request(16'd100, 1'b0);
        send_request(16'd1, 1'b1);
        settle();
    endtask

    // Random runs over many register settings
    task automatic test_random_runs();
        int                          target;
        logic [pfa_pkg::MODE_W-1:0]  m;
        logic [pfa_pkg::COUNT_W-1:0] n;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            settle();
            m = pfa_pkg::MODE_W'($urandom_range(0, 3));
            case ($urandom_range(9))
                0:       n = 5'd0;
                1:       n = 5'd1;
                2:       n = 5'd16;
                3:       n = pfa_pkg::COUNT_W'($urandom_range(17, 31));
                default: n = pfa_pkg::COUNT_W'($urandom_range(1, 16));
            endcase
            write_reg(pfa_pkg::REG_FIT_MODE, {3'($urandom_range(7)), m});
            write_reg(pfa_pkg::REG_PART_COUNT, n);
            repeat (6) run_round();
        end
        settle();
    endtask

    // Result side holds off while beats keep coming, so the input stalls
    task automatic test_backpressure();
        write_reg(pfa_pkg::REG_FIT_MODE, pfa_pkg::CFG_DATA_W'(pfa_pkg::MODE_WORST));
        write_reg(pfa_pkg::REG_PART_COUNT, 5'd16);
        hold_seq++;
        repeat (5) run_round();
        settle();
    endtask

    // A long stretch with no gaps and no stalls
    task automatic test_no_idle();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        write_reg(pfa_pkg::REG_FIT_MODE, pfa_pkg::CFG_DATA_W'(pfa_pkg::MODE_BEST));
        repeat (20) run_round();
        settle();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    initial
    begin
        for (int j = 0; j < NPART; j++)
        begin
            orig_size[j] = '0;
            cur_size[j]  = '0;
        end
        taken                 = '0;
        mode_reg              = pfa_pkg::FIT_MODE_RESET;
        count_reg             = pfa_pkg::PART_COUNT_RESET;
        gaps_on               = 1'b1;
        stall_on              = 1'b1;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        in_ch.valid           = 1'b0;
        in_ch.operation       = pfa_pkg::OP_LOAD;
        in_ch.partition_index = '0;
        in_ch.size_value      = '0;
        in_ch.last_request    = 1'b0;
        out_ch.ready          = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_fit_modes();
        test_count_limits();
        test_random_runs();
        test_backpressure();
        test_no_idle();

        settle();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
